// ----- rtl/hvps_pkg.sv -----
package hvps_pkg;

    // Field widths
    localparam int VoltW   = 9;
    localparam int TickW   = 8;
    localparam int ForceW  = 2;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 9;
    localparam int InDataW  = 16;
    localparam int OutDataW = 8;

    // Configuration register indexes
    localparam logic [CfgAddrW-1:0] CfgMinVoltage  = 3'd0;
    localparam logic [CfgAddrW-1:0] CfgSettleDelta = 3'd1;
    localparam logic [CfgAddrW-1:0] CfgSettleTicks = 3'd2;
    localparam logic [CfgAddrW-1:0] CfgFailTicks   = 3'd3;
    localparam logic [CfgAddrW-1:0] CfgForced      = 3'd4;

    // Register reset values
    localparam logic [VoltW-1:0] MinVoltageRst  = 9'd210;
    localparam logic [VoltW-1:0] SettleDeltaRst = 9'd5;
    localparam logic [TickW-1:0] SettleTicksRst = 8'd10;
    localparam logic [TickW-1:0] FailTicksRst   = 8'd25;

    // Test override selector
    typedef enum logic [ForceW-1:0] {
        FORCE_NONE = 2'd0,
        FORCE_PRE  = 2'd1,
        FORCE_POS  = 2'd2,
        FORCE_NEG  = 2'd3
    } t_force;

    // Status codes
    typedef enum logic [1:0] {
        HV_OFF      = 2'd0,
        HV_PRECHG   = 2'd1,
        HV_COMPLETE = 2'd2,
        HV_FAILED   = 2'd3
    } t_hv_status;

    // Contactor drive vector
    typedef struct packed {
        logic neg;
        logic pos;
        logic pre;
    } t_drives;

    localparam t_drives DrvOpen = '{neg: 1'b0, pos: 1'b0, pre: 1'b0};
    localparam t_drives DrvPrechg = '{neg: 1'b1, pos: 1'b0, pre: 1'b1};
    localparam t_drives DrvMains  = '{neg: 1'b1, pos: 1'b1, pre: 1'b0};

endpackage

// ----- rtl/hv_precharge_sequencer.sv -----
// Channel  | Direction | Payload                                           | Transaction
// ---------+-----------+---------------------------------------------------+----------------
// s_axis   | in        | tdata[0] ignition_on, tdata[9:1] bus_voltage       | tvalid & tready
// m_axis   | out       | tdata[0] precharge, [1] positive, [2] negative,    | tvalid & tready
//          |           | tdata[4:3] hv_status                               |
// i_cfg_*  | in        | i_cfg_addr register index, i_cfg_data value        | i_cfg_we
//
// One tick per cycle while m_axis is not stalled: its result sits in the output register
// from the next cycle, and the sequencer state advances on the edge that accepts a tick.
// i_rst_n is synchronous, active low: it restores the registers and clears all state.
// A stalled result holds in the output register; s_axis_tready stays high while that
// register is empty or being drained, so a new tick enters as the old result leaves.
module hv_precharge_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [0] ignition_on, [9:1] bus_voltage, [15:10] zero
    input  logic [hvps_pkg::InDataW-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] precharge_drive, [1] positive_drive, [2] negative_drive, [4:3] hv_status,
    // [7:5] zero
    output logic [hvps_pkg::OutDataW-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [hvps_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [hvps_pkg::CfgDataW-1:0] i_cfg_data
);
    import hvps_pkg::*;

    // Configuration registers
    logic [VoltW-1:0] r_min_voltage;
    logic [VoltW-1:0] r_settle_delta;
    logic [TickW-1:0] r_settle_ticks;
    logic [TickW-1:0] r_fail_ticks;
    t_force           r_forced;

    // Sequencer state
    logic [VoltW-1:0] r_ref_volt,   n_ref_volt;
    logic [TickW-1:0] r_steady_cnt, n_steady_cnt;
    logic [TickW-1:0] r_prechg_cnt, n_prechg_cnt;
    logic             r_complete,   n_complete;
    logic             r_failed,     n_failed;
    t_drives          r_drives,     n_drives;

    // Output register
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data, n_out_data;

    logic             in_accept;
    logic             ign;
    logic [VoltW-1:0] volt;
    logic [VoltW-1:0] diff;
    logic [TickW-1:0] steady_base;
    t_hv_status       status;
    t_drives          drv_out;

    assign ign  = s_axis_tdata[0];
    assign volt = s_axis_tdata[VoltW:1];

    // Take a new tick whenever the output register is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_ref_volt   = r_ref_volt;
        n_steady_cnt = r_steady_cnt;
        n_prechg_cnt = r_prechg_cnt;
        n_complete   = r_complete;
        n_failed     = r_failed;
        n_drives     = r_drives;
        diff         = (volt > r_ref_volt) ? volt - r_ref_volt : r_ref_volt - volt;
        steady_base  = r_steady_cnt;

        if (!ign || r_failed) begin
            // Drop everything; a latched failure retries from scratch next tick
            n_ref_volt   = '0;
            n_steady_cnt = '0;
            n_prechg_cnt = '0;
            n_complete   = 1'b0;
            n_failed     = 1'b0;
            n_drives     = DrvOpen;
        end else if (!r_complete) begin
            if (r_prechg_cnt > r_fail_ticks) begin
                // Latch failure, hold the drives for this tick
                n_failed = 1'b1;
            end else begin
                // Re-take the reference when the voltage moves beyond the window
                if (diff > r_settle_delta) begin
                    n_ref_volt  = volt;
                    steady_base = '0;
                end
                n_steady_cnt = (steady_base == '1) ? steady_base : steady_base + 1'b1;
                if (n_steady_cnt <= r_settle_ticks || n_ref_volt < r_min_voltage) begin
                    n_drives     = DrvPrechg;
                    n_prechg_cnt = (r_prechg_cnt == '1) ? r_prechg_cnt
                                                        : r_prechg_cnt + 1'b1;
                end else begin
                    n_prechg_cnt = '0;
                    n_complete   = 1'b1;
                    n_drives     = DrvMains;
                end
            end
        end

        if (n_failed) begin
            status = HV_FAILED;
        end else if (n_complete) begin
            status = HV_COMPLETE;
        end else if (ign) begin
            status = HV_PRECHG;
        end else begin
            status = HV_OFF;
        end

        // Test override ORs one contactor closed at the outputs only
        drv_out = n_drives;
        case (r_forced)
            FORCE_PRE: drv_out.pre = 1'b1;
            FORCE_POS: drv_out.pos = 1'b1;
            FORCE_NEG: drv_out.neg = 1'b1;
            default:   drv_out = n_drives;
        endcase

        n_out_data = {3'b000, status, drv_out.neg, drv_out.pos, drv_out.pre};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_voltage  <= MinVoltageRst;
            r_settle_delta <= SettleDeltaRst;
            r_settle_ticks <= SettleTicksRst;
            r_fail_ticks   <= FailTicksRst;
            r_forced       <= FORCE_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CfgMinVoltage:  r_min_voltage  <= i_cfg_data;
                CfgSettleDelta: r_settle_delta <= i_cfg_data;
                CfgSettleTicks: r_settle_ticks <= i_cfg_data[TickW-1:0];
                CfgFailTicks:   r_fail_ticks   <= i_cfg_data[TickW-1:0];
                CfgForced:      r_forced       <= t_force'(i_cfg_data[ForceW-1:0]);
                default:        r_forced       <= r_forced;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_volt   <= '0;
            r_steady_cnt <= '0;
            r_prechg_cnt <= '0;
            r_complete   <= 1'b0;
            r_failed     <= 1'b0;
            r_drives     <= DrvOpen;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_ref_volt   <= n_ref_volt;
                r_steady_cnt <= n_steady_cnt;
                r_prechg_cnt <= n_prechg_cnt;
                r_complete   <= n_complete;
                r_failed     <= n_failed;
                r_drives     <= n_drives;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ----- rtl/hvps_checker.sv -----
module hvps_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [hvps_pkg::InDataW-1:0]  s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [hvps_pkg::OutDataW-1:0] m_axis_tdata,
    input logic                          i_cfg_we,
    input logic [hvps_pkg::CfgAddrW-1:0] i_cfg_addr,
    input logic [hvps_pkg::CfgDataW-1:0] i_cfg_data
);
    import hvps_pkg::*;

    logic [1:0] status;
    logic       unused_in;

    assign status    = m_axis_tdata[4:3];
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ i_cfg_we
                       ^ (^i_cfg_addr) ^ (^i_cfg_data);

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // Complete means both main contactors closed
    a_complete_mains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == HV_COMPLETE |-> m_axis_tdata[1] && m_axis_tdata[2])
        else $error("complete without main contactors");

    // A failure only follows precharge ticks, so the precharge path is still held
    a_failed_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == HV_FAILED |-> m_axis_tdata[0] && m_axis_tdata[2])
        else $error("failure without precharge path held");

    // Off leaves at most the forced contactor closed
    a_off_open: assert property (@(posedge i_clk) disable iff (!i_rst_n || unused_in === 1'bx)
        m_axis_tvalid && status == HV_OFF |-> $countones(m_axis_tdata[2:0]) <= 1)
        else $error("contactors closed while off");

endmodule

bind hv_precharge_sequencer hvps_checker u_hvps_checker (.*);
